// File: hdl/spwh_pkg.sv
// spwh_pkg: shared widths and defaults for the sparse phrase window hash
// no dependencies
`timescale 1ns / 1ps

package spwh_pkg;

  localparam int WINDOW_PHRASES_DEF = 5;
  localparam int HASH_W             = 32;
  localparam int SUBSET_W           = 4;
  localparam int WARM_W             = 3;

endpackage

// File: hdl/spwh_issue.sv
// spwh_issue: head of the cell chain, holds the current item and issues one
// subset token per cycle while the chain advances. depends on spwh_pkg
`timescale 1ns / 1ps

module spwh_issue #(
  parameter int WINDOW_PHRASES = spwh_pkg::WINDOW_PHRASES_DEF,
  parameter int DEPTH          = WINDOW_PHRASES - 1
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       adv,
  input  logic                       phrase_valid,
  output logic                       phrase_stall,
  input  logic [spwh_pkg::HASH_W-1:0] phrase_hash,
  output logic                       tok_valid,
  output logic [spwh_pkg::HASH_W-1:0] tok_acc,
  output logic [spwh_pkg::HASH_W-1:0] tok_carry,
  output logic [DEPTH-1:0]           tok_idx,
  output logic                       tok_last
);
  import spwh_pkg::*;

  logic              busy;
  logic [HASH_W-1:0] cur;
  logic [DEPTH-1:0]  idx;
  logic [DEPTH-1:0]  last_idx;
  logic [DEPTH-1:0]  last_idx_next;
  logic [WARM_W-1:0] warm;
  logic              accept;

  assign tok_valid    = busy;
  assign tok_acc      = cur << 1;
  assign tok_carry    = cur;
  assign tok_idx      = idx;
  assign tok_last     = (idx == last_idx);
  assign phrase_stall = busy && !(adv && tok_last);
  assign accept       = phrase_valid && !phrase_stall;

  // 2^warm - 1 as a run of ones
  always_comb begin
    for (int b = 0; b < DEPTH; b++) begin
      last_idx_next[b] = (WARM_W'(b) < warm);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      warm <= '0;
    end else begin
      if (accept) begin
        busy <= 1'b1;
        if (warm < WARM_W'(DEPTH)) begin
          warm <= warm + WARM_W'(1);
        end
      end else if (adv && busy && tok_last) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur      <= phrase_hash;
      idx      <= '0;
      last_idx <= last_idx_next;
    end else if (adv && busy && !tok_last) begin
      idx <= idx + DEPTH'(1);
    end
  end

endmodule

// File: hdl/spwh_cell.sv
// spwh_cell: one window cell, holds one previous hash, adds its weighted term
// and shifts the window at item boundaries. depends on spwh_pkg
`timescale 1ns / 1ps

module spwh_cell #(
  parameter int DEPTH  = spwh_pkg::WINDOW_PHRASES_DEF - 1,
  parameter int CELL_K = 0
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        adv,
  input  logic                        in_valid,
  input  logic [spwh_pkg::HASH_W-1:0] in_acc,
  input  logic [spwh_pkg::HASH_W-1:0] in_carry,
  input  logic [DEPTH-1:0]            in_idx,
  input  logic                        in_last,
  output logic                        out_valid,
  output logic [spwh_pkg::HASH_W-1:0] out_acc,
  output logic [spwh_pkg::HASH_W-1:0] out_carry,
  output logic [DEPTH-1:0]            out_idx,
  output logic                        out_last
);
  import spwh_pkg::*;

  logic [HASH_W-1:0] prev;
  logic [HASH_W-1:0] term;

  // weight 2^k times (2^(k+1) + 1)
  assign term = in_idx[CELL_K] ? ((prev << (2 * CELL_K + 1)) + (prev << CELL_K)) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      prev      <= '0;
    end else if (adv) begin
      out_valid <= in_valid;
      if (in_valid && in_last) begin
        prev <= in_carry;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_acc   <= in_acc + term;
      out_carry <= prev;
      out_idx   <= in_idx;
      out_last  <= in_last;
    end
  end

endmodule

// File: hdl/sparse_phrase_window_hash.sv
// sparse_phrase_window_hash: sparse polynomial hashes over a phrase window
// the item is registered at the chain head, and each token then passes through the cells
// throughput: one result per cycle unless result_stall holds the chain; once warm,
// 2^(WINDOW_PHRASES-1) results per item (16 at default), issued singly by the head
// reset: window hashes and warm-up count cleared, no item in flight
// depends on spwh_pkg, spwh_issue, spwh_cell
`timescale 1ns / 1ps

module sparse_phrase_window_hash #(
  parameter int WINDOW_PHRASES = spwh_pkg::WINDOW_PHRASES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          phrase_valid,
  output logic                          phrase_stall,
  input  logic [spwh_pkg::HASH_W-1:0]   phrase_hash,
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic [spwh_pkg::HASH_W-1:0]   hash_value,
  output logic [spwh_pkg::SUBSET_W-1:0] subset_index,
  output logic                          last
);
  import spwh_pkg::*;

  localparam int DEPTH = WINDOW_PHRASES - 1;

  logic                    adv;
  logic [DEPTH:0]          ch_valid;
  logic [HASH_W-1:0]       ch_acc   [DEPTH+1];
  logic [HASH_W-1:0]       ch_carry [DEPTH+1];
  logic [DEPTH-1:0]        ch_idx   [DEPTH+1];
  logic [DEPTH:0]          ch_last;
  logic [DEPTH+SUBSET_W-1:0] idx_ext;

  assign adv = !ch_valid[DEPTH] || !result_stall;

  spwh_issue #(
    .WINDOW_PHRASES(WINDOW_PHRASES),
    .DEPTH(DEPTH)
  ) u_issue (
    .clk(clk),
    .rst(rst),
    .adv(adv),
    .phrase_valid(phrase_valid),
    .phrase_stall(phrase_stall),
    .phrase_hash(phrase_hash),
    .tok_valid(ch_valid[0]),
    .tok_acc(ch_acc[0]),
    .tok_carry(ch_carry[0]),
    .tok_idx(ch_idx[0]),
    .tok_last(ch_last[0])
  );

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    spwh_cell #(
      .DEPTH(DEPTH),
      .CELL_K(k)
    ) u_cell (
      .clk(clk),
      .rst(rst),
      .adv(adv),
      .in_valid(ch_valid[k]),
      .in_acc(ch_acc[k]),
      .in_carry(ch_carry[k]),
      .in_idx(ch_idx[k]),
      .in_last(ch_last[k]),
      .out_valid(ch_valid[k+1]),
      .out_acc(ch_acc[k+1]),
      .out_carry(ch_carry[k+1]),
      .out_idx(ch_idx[k+1]),
      .out_last(ch_last[k+1])
    );
  end

  assign idx_ext      = {{SUBSET_W{1'b0}}, ch_idx[DEPTH]};
  assign result_valid = ch_valid[DEPTH];
  assign hash_value   = ch_acc[DEPTH];
  assign subset_index = idx_ext[SUBSET_W-1:0];
  assign last         = ch_last[DEPTH];

endmodule
